FILE: sv/todt_pkg.sv
// Shared types and constants for the temperature outlier / delta trigger block.
// No dependencies; used by every module of the block.
`default_nettype none

package todt_pkg;

   localparam int POOL_DEPTH_DEF = 8;
   localparam int DATA_W         = 16;
   localparam int OFFSET_W       = 9;
   localparam int CSR_ADDR_W     = 2;
   localparam int RSP_W          = 56;

   localparam logic [DATA_W-1:0] INVALID_MARK    = 16'hdead;
   localparam logic [DATA_W-1:0] DEV_LIMIT_RESET = 16'd160;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_OFFSET = 2'd0,
      CSR_DELTA  = 2'd1,
      CSR_LIMIT  = 2'd2,
      CSR_BYTE   = 2'd3
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SUM,
      ST_DIV,
      ST_WAIT,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

FILE: sv/todt_div.sv
// Bit-serial signed divider: truncating quotient of a signed sum by a small count.
// Uses todt_pkg for the data width.
`default_nettype none

module todt_div #(
   parameter int SUM_W = 20,
   parameter int CNT_W = 4
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic signed [SUM_W-1:0]       dividend,
   input  wire logic        [CNT_W-1:0]       divisor,
   output      logic                          done,
   output      logic signed [todt_pkg::DATA_W-1:0] quotient
);

   localparam int STEP_W = $clog2(SUM_W + 1);

   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W:0]    rem_ff, rem_in;
   logic [CNT_W-1:0]  dvs_ff;
   logic              neg_ff;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              done_ff, done_in;

   logic [CNT_W:0]    trial;
   logic              fits;
   logic [SUM_W-1:0]  mag;
   logic [SUM_W-1:0]  signed_quo;

   assign mag   = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
   assign trial = {rem_ff[CNT_W-1:0], quo_ff[SUM_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      quo_in  = {quo_ff[SUM_W-2:0], fits};
      rem_in  = fits ? (trial - {1'b0, dvs_ff}) : trial;
      step_in = step_ff - 1'b1;
      done_in = (step_ff == STEP_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
      end else if (start) begin
         step_ff <= STEP_W'(SUM_W);
         done_ff <= 1'b0;
      end else if (step_ff != '0) begin
         step_ff <= step_in;
         done_ff <= done_in;
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= mag;
         rem_ff <= '0;
         dvs_ff <= divisor;
         neg_ff <= dividend[SUM_W-1];
      end else if (step_ff != '0) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign signed_quo = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
   assign quotient   = signed_quo[todt_pkg::DATA_W-1:0];
   assign done       = done_ff;

endmodule

`default_nettype wire

FILE: sv/temperature_outlier_delta_trigger.sv
// Temperature outlier filter with delta-send trigger, top level.
// Depends on todt_pkg and todt_div (running mean divider).
//
// Usage:
//   req_ channel: one finished sensor reading per transfer. req_tdata holds the
//   raw reading (signed, 1/16 degree), req_tuser the reading-ok flag.
//   rsp_ channel: exactly one result per request, in order.
//   csr_ port: write-only registers (offset, delta threshold, deviation limit,
//   byte format), which the user must write only while the block is idle; the block does not enforce this.
// Sequencing:
//   A bad reading goes from IDLE straight to DONE, skipping the mean update.
//   A good reading passes READ, SUM, DIV, WAIT and DONE; in WAIT the
//   bit-serial mean divider works, one quotient bit per cycle over SUM_W bits.
//   One reading is processed at a time; a new request transfer can be taken
//   in the cycle after the previous result is loaded into the output register.
// Reset: sample sum, mean, fill count and write position clear, the kept
//   temperature becomes the invalid marker, the trigger disarms, registers
//   take their reset values. The sample ring needs no clearing: entries are
//   read only once the ring has wrapped.
// Stall: the result sits in the output register until rsp_tready; the next
//   request may already be taken and worked on meanwhile, and its result waits
//   for the register to free up.
`default_nettype none

module temperature_outlier_delta_trigger #(
   parameter int POOL_DEPTH = todt_pkg::POOL_DEPTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   input  wire logic [todt_pkg::DATA_W-1:0]         req_tdata,  // [15:0] raw_reading
   input  wire logic                                req_tuser,  // [0] reading_ok
   // result channel
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [0] sample_accepted, [16:1] deviation, [32:17] current_temperature,
   // [33] send_now, [49:34] send_value, [55:50] zero
   output      logic [todt_pkg::RSP_W-1:0]          rsp_tdata,
   // register write port
   input  wire logic                                csr_we,
   input  wire logic [todt_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  wire logic [todt_pkg::DATA_W-1:0]         csr_wdata
);

   localparam int DW    = todt_pkg::DATA_W;
   localparam int POS_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int CNT_W = $clog2(POOL_DEPTH + 1);
   // sum of up to POOL_DEPTH + 1 samples during the update
   localparam int SUM_W = DW + 1 + $clog2(POOL_DEPTH);

   // ---------------- configuration registers ----------------
   logic [todt_pkg::OFFSET_W-1:0] offset_ff;
   logic [DW-1:0]                 delta_ff;
   logic [DW-1:0]                 limit_ff;
   logic                          byte_fmt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff   <= '0;
         delta_ff    <= '0;
         limit_ff    <= todt_pkg::DEV_LIMIT_RESET;
         byte_fmt_ff <= 1'b0;
      end else if (csr_we) begin
         case (todt_pkg::csr_idx_type'(csr_addr))
            todt_pkg::CSR_OFFSET: offset_ff   <= csr_wdata[todt_pkg::OFFSET_W-1:0];
            todt_pkg::CSR_DELTA:  delta_ff    <= csr_wdata;
            todt_pkg::CSR_LIMIT:  limit_ff    <= csr_wdata;
            todt_pkg::CSR_BYTE:   byte_fmt_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ---------------- sequencer ----------------
   todt_pkg::state_type state_ff, state_in;
   logic req_xfer;
   logic rsp_load;
   logic div_start;
   logic div_done;
   logic signed [DW-1:0] div_quot;

   assign req_tready = (state_ff == todt_pkg::ST_IDLE);
   assign req_xfer   = req_tvalid & req_tready;

   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         todt_pkg::ST_IDLE: begin
            if (req_xfer) begin
               state_in = req_tuser ? todt_pkg::ST_READ : todt_pkg::ST_DONE;
            end
         end
         todt_pkg::ST_READ: state_in = todt_pkg::ST_SUM;
         todt_pkg::ST_SUM:  state_in = todt_pkg::ST_DIV;
         todt_pkg::ST_DIV: begin
            div_start = 1'b1;
            state_in  = todt_pkg::ST_WAIT;
         end
         todt_pkg::ST_WAIT: begin
            if (div_done) begin
               state_in = todt_pkg::ST_DONE;
            end
         end
         todt_pkg::ST_DONE: begin
            // output register must be free (or draining) before the result lands
            if (!rsp_tvalid || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = todt_pkg::ST_IDLE;
            end
         end
         default: state_in = todt_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= todt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------- per-item working registers ----------------
   logic          ok_ff;
   logic [DW-1:0] adj_ff, adj_in;
   logic [DW-1:0] dev_ff, dev_in;

   // offset added with 16-bit wrap
   assign adj_in = req_tdata + {{(DW - todt_pkg::OFFSET_W){offset_ff[todt_pkg::OFFSET_W-1]}},
                                offset_ff};

   // ---------------- ring memory and running state ----------------
   logic [DW-1:0]              ring_mem [POOL_DEPTH];
   logic [DW-1:0]              ring_rd_ff;
   logic [POS_W-1:0]           pos_ff, pos_in;
   logic [CNT_W-1:0]           fill_ff, fill_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic signed [DW-1:0]       mean_ff;
   logic                       ring_full;
   logic                       ring_we;

   assign ring_full = (fill_ff == CNT_W'(POOL_DEPTH));
   assign ring_we   = (state_ff == todt_pkg::ST_SUM);

   // read-first: the entry at pos is fetched in READ, overwritten in SUM
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[pos_ff] <= adj_ff;
      end
      ring_rd_ff <= ring_mem[pos_ff];
   end

   // deviation of the new sample from the mean before this item
   logic signed [DW:0] mean_diff;
   logic        [DW:0] mean_absdiff;
   assign mean_diff    = {mean_ff[DW-1], mean_ff} - {adj_ff[DW-1], adj_ff};
   assign mean_absdiff = mean_diff[DW] ? (~mean_diff + 1'b1) : mean_diff;
   assign dev_in       = (fill_ff == '0) ? '0 : mean_absdiff[DW-1:0];

   // sum update: add new sample, drop the oldest once the ring is full
   always_comb begin
      sum_in  = sum_ff + {{(SUM_W - DW){adj_ff[DW-1]}}, adj_ff};
      fill_in = fill_ff;
      if (ring_full) begin
         sum_in = sum_in - {{(SUM_W - DW){ring_rd_ff[DW-1]}}, ring_rd_ff};
      end else begin
         fill_in = fill_ff + 1'b1;
      end
      pos_in = (pos_ff == POS_W'(POOL_DEPTH - 1)) ? '0 : pos_ff + 1'b1;
   end

   todt_div #(
      .SUM_W (SUM_W),
      .CNT_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (fill_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   // ---------------- outlier check and delta trigger ----------------
   logic [DW-1:0] kept_ff;
   logic [DW-1:0] last_ff;
   logic          armed_ff;

   logic          accepted;
   logic [DW-1:0] kept_new;
   logic signed [DW:0] trig_diff;
   logic        [DW:0] trig_abs;
   logic          trig_on;
   logic          arm_now;
   logic          fire;
   logic [DW-1:0] byte_src;
   logic [DW-1:0] send_value;

   assign accepted  = ok_ff & (dev_ff < limit_ff);
   assign kept_new  = accepted ? adj_ff : kept_ff;
   assign trig_diff = {kept_new[DW-1], kept_new} - {last_ff[DW-1], last_ff};
   assign trig_abs  = trig_diff[DW] ? (~trig_diff + 1'b1) : trig_diff;
   assign trig_on   = ok_ff & (delta_ff != '0);
   assign arm_now   = trig_on & ~armed_ff & (kept_new != todt_pkg::INVALID_MARK);
   assign fire      = trig_on & armed_ff & (trig_abs > {1'b0, delta_ff});
   // divide by 16 toward zero: bias negatives before the shift
   assign byte_src  = kept_new[DW-1] ? kept_new + DW'(15) : kept_new;
   always_comb begin
      send_value = '0;
      if (fire) begin
         send_value = byte_fmt_ff ? {8'd0, byte_src[11:4]} : kept_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         fill_ff  <= '0;
         sum_ff   <= '0;
         mean_ff  <= '0;
         kept_ff  <= todt_pkg::INVALID_MARK;
         last_ff  <= '0;
         armed_ff <= 1'b0;
      end else begin
         if (ring_we) begin
            pos_ff  <= pos_in;
            fill_ff <= fill_in;
            sum_ff  <= sum_in;
         end
         if (state_ff == todt_pkg::ST_WAIT && div_done) begin
            mean_ff <= div_quot;
         end
         if (rsp_load) begin
            kept_ff <= kept_new;
            if (arm_now || fire) begin
               last_ff <= kept_new;
            end
            if (arm_now) begin
               armed_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         ok_ff  <= req_tuser;
         adj_ff <= adj_in;
         dev_ff <= '0;
      end else if (state_ff == todt_pkg::ST_READ) begin
         dev_ff <= dev_in;
      end
   end

   // ---------------- output register ----------------
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [todt_pkg::RSP_W-1:0]  rsp_data_ff;

   assign rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= {6'd0, send_value, fire, kept_new, dev_ff, accepted};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: sv/todt_checker.sv
// Port-level checks for temperature_outlier_delta_trigger, bound to the top level.
// Uses todt_pkg for the result width.
`default_nettype none

module todt_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       rsp_tvalid,
   input wire logic                       rsp_tready,
   input wire logic [todt_pkg::RSP_W-1:0] rsp_tdata
);

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // a stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // send value is zero unless a send fires
   a_no_send_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[33] |-> rsp_tdata[49:34] == 16'd0)
      else $error("send value without send");

   // the top pad bits of the result stay zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[55:50] == 6'd0)
      else $error("result pad bits set");

endmodule

bind temperature_outlier_delta_trigger todt_checker u_todt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
